@@ hw/rtl/urh_pkg.sv @@
// ----------------------------------------------------------------------------
// urh_pkg
// Shared types and constants for the undo/redo history ring.
// ----------------------------------------------------------------------------
package urh_pkg;

  localparam int CMD_W         = 3;
  localparam int SNAP_W        = 64;
  localparam int CFG_W         = 9;
  localparam int SLOTS_DEF     = 256;
  localparam int SNAP_BITS_DEF = 64;

  localparam logic [CFG_W-1:0] DEPTH_RST = 9'd256;

  typedef enum logic [CMD_W-1:0] {
    CMD_STORE  = 3'd0,
    CMD_UNDO   = 3'd1,
    CMD_REDO   = 3'd2,
    CMD_RELOAD = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_RESP
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic exec;      // input beat taken: update pointers, issue RAM access
    logic load_out;  // capture result into output register
  } ctrl_cmd_t;

endpackage

@@ hw/rtl/urh_ram.sv @@
// ----------------------------------------------------------------------------
// urh_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module urh_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic              re,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/urh_ctrl.sv @@
// ----------------------------------------------------------------------------
// urh_ctrl
// Handshake controller: takes one command beat, waits for the RAM read,
// then moves the result into the output register.
// ----------------------------------------------------------------------------
module urh_ctrl
  import urh_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output ctrl_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd.exec     = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.exec = in_valid;
      end
      ST_RESP: begin
        cmd.load_out = !out_valid_r || out_ready;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_exec_then_resp: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> state_r == ST_RESP)
    else $error("accepted beat did not enter response state");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("loaded result not presented");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.exec && cmd.load_out))
    else $error("accept and result load in same cycle");

  a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESP && out_valid_r && !out_ready) |=> state_r == ST_RESP)
    else $error("result dropped while output stalled");

endmodule

@@ hw/rtl/urh_dp.sv @@
// ----------------------------------------------------------------------------
// urh_dp
// History pointers, depth register, snapshot RAM and output register.
// ----------------------------------------------------------------------------
module urh_dp
  import urh_pkg::*;
#(
  parameter int SLOTS     = SLOTS_DEF,
  parameter int SNAP_BITS = SNAP_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ctrl_cmd_t         cmd,
  input  logic              cfg_valid,
  input  logic [CFG_W-1:0]  cfg_depth_in_use,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic [SNAP_W-1:0] in_snapshot_in,
  output logic              out_ok,
  output logic [SNAP_W-1:0] out_snapshot_out,
  output logic              out_snapshot_valid
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int SW_W   = $clog2(SLOTS + 1);
  localparam int D_W    = (SW_W > CFG_W) ? SW_W : CFG_W;

  logic [CFG_W-1:0]  depth_r;
  logic              has_r, has_nxt;
  logic [SLOT_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt, old_r, old_nxt;
  logic              ok_p_r, ok_p_nxt, sv_p_r, sv_p_nxt;
  logic              out_ok_r, out_sv_r;
  logic [SNAP_W-1:0] out_snap_r;

  logic [D_W-1:0]    dz, d, dm1_w, rd_inc, old_inc;
  logic [SLOT_W-1:0] dm1, next_rd, next_old, prev_rd, wr_new, ram_addr;
  logic              we_c, re_c;
  logic [SNAP_BITS-1:0] ram_rdata;

  // live depth clamped to 2..SLOTS
  always_comb begin
    dz = D_W'(depth_r);
    if (dz < D_W'(2)) begin
      d = D_W'(2);
    end else if (dz > D_W'(SLOTS)) begin
      d = D_W'(SLOTS);
    end else begin
      d = dz;
    end
  end

  assign dm1_w    = d - D_W'(1);
  assign dm1      = dm1_w[SLOT_W-1:0];
  assign rd_inc   = D_W'(rd_r) + D_W'(1);
  assign old_inc  = D_W'(old_r) + D_W'(1);
  assign next_rd  = (rd_inc >= d) ? '0 : rd_inc[SLOT_W-1:0];
  assign next_old = (old_inc >= d) ? '0 : old_inc[SLOT_W-1:0];
  assign prev_rd  = (rd_r == '0) ? dm1 : rd_r - SLOT_W'(1);

  always_comb begin
    has_nxt  = has_r;
    wr_nxt   = wr_r;
    rd_nxt   = rd_r;
    old_nxt  = old_r;
    ok_p_nxt = 1'b0;
    sv_p_nxt = 1'b0;
    we_c     = 1'b0;
    re_c     = 1'b0;
    wr_new   = next_rd;
    ram_addr = rd_r;
    unique case (in_cmd)
      CMD_STORE: begin
        if (!has_r) begin
          wr_new  = '0;
          old_nxt = dm1;
          has_nxt = 1'b1;
        end else if (next_rd == old_r) begin
          old_nxt = next_old;
        end
        wr_nxt   = wr_new;
        rd_nxt   = wr_new;
        ram_addr = wr_new;
        we_c     = 1'b1;
        ok_p_nxt = 1'b1;
      end
      CMD_UNDO: begin
        if (has_r && prev_rd != old_r) begin
          rd_nxt   = prev_rd;
          ram_addr = prev_rd;
          re_c     = 1'b1;
          ok_p_nxt = 1'b1;
          sv_p_nxt = 1'b1;
        end
      end
      CMD_REDO: begin
        if (has_r && rd_r != wr_r) begin
          rd_nxt   = next_rd;
          ram_addr = next_rd;
          re_c     = 1'b1;
          ok_p_nxt = 1'b1;
          sv_p_nxt = 1'b1;
        end
      end
      CMD_RELOAD: begin
        if (has_r) begin
          re_c     = 1'b1;
          ok_p_nxt = 1'b1;
          sv_p_nxt = 1'b1;
        end
      end
      CMD_CLEAR: begin
        has_nxt  = 1'b0;
        ok_p_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= DEPTH_RST;
      has_r   <= 1'b0;
      wr_r    <= '0;
      rd_r    <= '0;
      old_r   <= '0;
    end else begin
      if (cfg_valid) depth_r <= cfg_depth_in_use;
      if (cmd.exec) begin
        has_r <= has_nxt;
        wr_r  <= wr_nxt;
        rd_r  <= rd_nxt;
        old_r <= old_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      ok_p_r <= ok_p_nxt;
      sv_p_r <= sv_p_nxt;
    end
    if (cmd.load_out) begin
      out_ok_r   <= ok_p_r;
      out_sv_r   <= sv_p_r;
      out_snap_r <= sv_p_r ? SNAP_W'(ram_rdata) : '0;
    end
  end

  urh_ram #(
    .WIDTH (SNAP_BITS),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.exec && we_c),
    .re    (cmd.exec && re_c),
    .addr  (ram_addr),
    .wdata (in_snapshot_in[SNAP_BITS-1:0]),
    .rdata (ram_rdata)
  );

  assign out_ok             = out_ok_r;
  assign out_snapshot_out   = out_snap_r;
  assign out_snapshot_valid = out_sv_r;

  a_store_sets_history: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && in_cmd == CMD_STORE) |=> has_r && rd_r == wr_r)
    else $error("store did not leave read position on newest entry");

  a_clear_drops_history: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && in_cmd == CMD_CLEAR) |=> !has_r)
    else $error("clear left history behind");

endmodule

@@ hw/rtl/undo_redo_history_ring.sv @@
// ----------------------------------------------------------------------------
// undo_redo_history_ring
// Undo/redo history of snapshot words kept in a ring of RAM slots.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one command beat (cmd, snapshot_in) per valid/ready handshake.
//            Commands: store, undo, redo, reload current, clear.
//   out_*  : exactly one result beat per command (ok, snapshot_out,
//            snapshot_valid); snapshot_out is zero unless snapshot_valid.
//   cfg_*  : write of depth_in_use (slots in use, clamped to 2..SLOTS);
//            cfg_ready is always high. Write only while the block is idle.
// Timing:
//   A command is taken in the idle state, which issues the RAM access; the
//   registered read data is ready in the response state, and the result
//   register loads at the end of that state unless the previous result is
//   still held. No new command is taken before the last one's result
//   has loaded into the output register. A new command may be taken
//   while the last result still waits in the output register.
// Reset: history empty, depth_in_use = 256, pointers zero. The snapshot
//   RAM is not cleared; no slot is read before it is written.
// Stall: while out_ready is low the result holds and in_ready drops once
//   the next command reaches its response cycle.
// ----------------------------------------------------------------------------
module undo_redo_history_ring
  import urh_pkg::*;
#(
  parameter int SLOTS     = SLOTS_DEF,
  parameter int SNAP_BITS = SNAP_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_depth_in_use,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic [SNAP_W-1:0] in_snapshot_in,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_ok,
  output logic [SNAP_W-1:0] out_snapshot_out,
  output logic              out_snapshot_valid
);

  ctrl_cmd_t cmd;

  assign cfg_ready = 1'b1;

  urh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  urh_dp #(
    .SLOTS     (SLOTS),
    .SNAP_BITS (SNAP_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .cfg_valid          (cfg_valid),
    .cfg_depth_in_use   (cfg_depth_in_use),
    .in_cmd             (in_cmd),
    .in_snapshot_in     (in_snapshot_in),
    .out_ok             (out_ok),
    .out_snapshot_out   (out_snapshot_out),
    .out_snapshot_valid (out_snapshot_valid)
  );

endmodule
